### hw/rtl/font_text_pixel_generator_unit_assert.svh
// Assertion macros for the font text pixel generator.
// Included by the top level; compiles to nothing under SYNTHESIS.
`ifndef FONT_TEXT_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define FONT_TEXT_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FTPG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftpg assertion failed");
`define FTPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftpg assertion failed");
`else
`define FTPG_ASSERT_IMPL(lbl, ante, cons)
`define FTPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/ftpg_pkg.sv
// Shared types, constants and the 5x7 font for the font text pixel generator.
// No dependencies.
`default_nettype none
package ftpg_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 64;
  localparam int QUEUE_DEPTH_DEF    = 2;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [3:0] ADVANCE_X    = 4'd6;
  localparam logic [3:0] ADVANCE_Y    = 4'd8;

  typedef struct packed {
    logic [GLYPH_BITS-1:0] mask;
    logic [15:0]           col;
    logic [15:0]           row;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [3:0] d);
    logic [16:0] s;
    s = {1'b0, v} + {13'd0, d};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [GLYPH_BITS-1:0] rows5(input logic [4:0] r0, input logic [4:0] r1,
                                                 input logic [4:0] r2, input logic [4:0] r3,
                                                 input logic [4:0] r4, input logic [4:0] r5,
                                                 input logic [4:0] r6);
    return {r6, r5, r4, r3, r2, r1, r0};
  endfunction

  // row r occupies bits [5r+4:5r]; glyph column 0 is the high bit of each row
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0]            k;
    logic [GLYPH_BITS-1:0] g;
    k = code;
    if (k >= 8'h61 && k <= 8'h7A) begin
      k = k - 8'd32;
    end
    unique case (k)
      8'h21: g = rows5(5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04);
      8'h42: g = rows5(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E);
      8'h45: g = rows5(5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F);
      8'h48: g = rows5(5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11);
      8'h4C: g = rows5(5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F);
      8'h4E: g = rows5(5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11);
      8'h4F: g = rows5(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h50: g = rows5(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10);
      8'h52: g = rows5(5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11);
      8'h53: g = rows5(5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E);
      8'h54: g = rows5(5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
      8'h55: g = rows5(5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h30: g = rows5(5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E);
      8'h31: g = rows5(5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E);
      8'h32: g = rows5(5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F);
      8'h33: g = rows5(5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E);
      8'h34: g = rows5(5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02);
      8'h35: g = rows5(5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E);
      8'h36: g = rows5(5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E);
      8'h37: g = rows5(5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08);
      8'h38: g = rows5(5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E);
      8'h39: g = rows5(5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ftpg_front.sv
// Front part: accepts characters, tracks the text cursor, looks up the glyph
// and forms the on-display pixel mask. Depends on ftpg_pkg.
`default_nettype none
module ftpg_front #(
  parameter int DISPLAY_WIDTH  = ftpg_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = ftpg_pkg::DISPLAY_HEIGHT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [23:0]   in_tdata,
  input  wire logic          in_tuser,
  input  wire logic          q_full,
  output logic               q_push,
  output ftpg_pkg::cmd_t     q_data
);

  localparam logic [16:0] W_LIM = 17'(DISPLAY_WIDTH);
  localparam logic [16:0] H_LIM = 17'(DISPLAY_HEIGHT);

  logic [15:0] cursor_col_r, cursor_col_nxt;
  logic [15:0] cursor_row_r, cursor_row_nxt;
  logic [7:0]  line_start_r, line_start_nxt;

  logic [7:0]  code;
  logic [15:0] col_cur, row_cur;
  logic [7:0]  ls_cur;
  logic [ftpg_pkg::GLYPH_BITS-1:0] glyph, mask;
  logic [ftpg_pkg::GLYPH_COLS-1:0] col_ok;
  logic [ftpg_pkg::GLYPH_ROWS-1:0] row_ok;
  logic accept, is_nl;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign code      = in_tdata[7:0];
  assign is_nl     = (code == ftpg_pkg::CODE_NEWLINE);
  assign col_cur   = in_tuser ? {8'd0, in_tdata[15:8]} : cursor_col_r;
  assign row_cur   = in_tuser ? {8'd0, in_tdata[23:16]} : cursor_row_r;
  assign ls_cur    = in_tuser ? in_tdata[15:8] : line_start_r;
  assign glyph     = ftpg_pkg::glyph_bits(code);

  always_comb begin
    for (int c = 0; c < ftpg_pkg::GLYPH_COLS; c++) begin
      col_ok[c] = ({1'b0, col_cur} + 17'(c)) < W_LIM;
    end
    for (int r = 0; r < ftpg_pkg::GLYPH_ROWS; r++) begin
      row_ok[r] = ({1'b0, row_cur} + 17'(r)) < H_LIM;
    end
    for (int r = 0; r < ftpg_pkg::GLYPH_ROWS; r++) begin
      for (int c = 0; c < ftpg_pkg::GLYPH_COLS; c++) begin
        mask[r*ftpg_pkg::GLYPH_COLS + c] =
          glyph[r*ftpg_pkg::GLYPH_COLS + (ftpg_pkg::GLYPH_COLS - 1 - c)] & col_ok[c] & row_ok[r];
      end
    end
  end

  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    line_start_nxt = line_start_r;
    if (accept) begin
      line_start_nxt = ls_cur;
      if (is_nl) begin
        cursor_row_nxt = ftpg_pkg::sat_add(row_cur, ftpg_pkg::ADVANCE_Y);
        cursor_col_nxt = {8'd0, ls_cur};
      end else begin
        cursor_row_nxt = row_cur;
        cursor_col_nxt = ftpg_pkg::sat_add(col_cur, ftpg_pkg::ADVANCE_X);
      end
    end
  end

  assign q_push      = accept && !is_nl && (|mask);
  assign q_data.mask = mask;
  assign q_data.col  = col_cur;
  assign q_data.row  = row_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      line_start_r <= '0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      line_start_r <= line_start_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ftpg_fifo.sv
// Short command queue between the front and back parts.
// Depends on ftpg_pkg for the command type.
`default_nettype none
module ftpg_fifo #(
  parameter int DEPTH = ftpg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ftpg_pkg::cmd_t wr_data,
  output logic                full,
  input  wire logic           pop,
  output ftpg_pkg::cmd_t      rd_data,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ftpg_pkg::cmd_t store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ftpg_back.sv
// Back part: scans the glyph mask one bit position per cycle, a set bit waiting
// for a free output register; emits mirrored pixel coordinates. Depends on ftpg_pkg.
`default_nettype none
module ftpg_back #(
  parameter int DISPLAY_WIDTH = ftpg_pkg::DISPLAY_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire ftpg_pkg::cmd_t   q_data,
  output logic                  q_pop,
  input  wire logic             ink,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [15:0]           out_tdata,
  output logic                  out_tlast,
  output ftpg_pkg::back_stat_t  stat
);

  localparam logic [16:0] X_MAX = 17'(DISPLAY_WIDTH - 1);
  localparam int MB = ftpg_pkg::GLYPH_BITS;

  logic          busy_r, busy_nxt;
  logic [MB-1:0] mask_r, mask_nxt;
  logic [15:0]   col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [2:0]    gc_r, gc_nxt;
  logic [2:0]    gr_r, gr_nxt;

  logic          ovalid_r, ovalid_nxt;
  logic [6:0]    px_r, px_nxt;
  logic [5:0]    py_r, py_nxt;
  logic          pc_r, pc_nxt;
  logic          plast_r, plast_nxt;

  logic free, emit, rest_zero, step, done;
  logic [16:0] xm;

  assign free      = !ovalid_r || out_tready;
  assign emit      = busy_r && mask_r[0] && free;
  assign rest_zero = (mask_r[MB-1:1] == '0);
  assign step      = busy_r && (!mask_r[0] || free);
  assign done      = emit && rest_zero;
  assign q_pop     = !q_empty && (!busy_r || done);
  assign xm        = X_MAX - ({1'b0, col_r} + {14'd0, gc_r});

  always_comb begin
    busy_nxt = busy_r;
    mask_nxt = mask_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    gc_nxt   = gc_r;
    gr_nxt   = gr_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      mask_nxt = q_data.mask;
      col_nxt  = q_data.col;
      row_nxt  = q_data.row;
      gc_nxt   = '0;
      gr_nxt   = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      mask_nxt = mask_r >> 1;
      if (gc_r == 3'(ftpg_pkg::GLYPH_COLS - 1)) begin
        gc_nxt = '0;
        gr_nxt = gr_r + 1'b1;
      end else begin
        gc_nxt = gc_r + 1'b1;
      end
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pc_nxt     = pc_r;
    plast_nxt  = plast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      px_nxt     = xm[6:0];
      py_nxt     = row_r[5:0] + {3'd0, gr_r};
      pc_nxt     = ink;
      plast_nxt  = rest_zero;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
    mask_r  <= mask_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    gc_r    <= gc_nxt;
    gr_r    <= gr_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pc_r    <= pc_nxt;
    plast_r <= plast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, pc_r, py_r, px_r};
  assign out_tlast  = plast_r;
  assign stat.busy  = busy_r;

endmodule
`default_nettype wire

### hw/rtl/font_text_pixel_generator_unit.sv
// Font text pixel generator: turns a character stream into display pixel
// writes using a built-in 5x7 font. A newline, space, unknown code or a glyph
// lying wholly off the display is handled by the front part alone and gives
// no pixel. A drawable glyph is scanned by the back part one of its 35 bit
// positions per cycle, a set bit waiting while the output stalls, up to its last
// surviving pixel, emitting at most one pixel per cycle; a two-entry command queue
// lets the front accept the following characters while a glyph is scanned.
// Depends on ftpg_pkg, ftpg_front, ftpg_fifo, ftpg_back and the assert header.
`default_nettype none
`include "font_text_pixel_generator_unit_assert.svh"
module font_text_pixel_generator_unit #(
  parameter int DISPLAY_WIDTH  = ftpg_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = ftpg_pkg::DISPLAY_HEIGHT_DEF,
  parameter int QUEUE_DEPTH    = ftpg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], origin_x[15:8], origin_y[23:16]
  input  wire logic        in_tuser,   // new_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // pixel_x[6:0], pixel_y[12:7], pixel_color[13], zero
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  logic ink_r;
  logic q_push, q_pop, q_full, q_empty;
  ftpg_pkg::cmd_t q_wr, q_rd;
  ftpg_pkg::back_stat_t back_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ink_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      ink_r <= cfg_data;
    end
  end

  ftpg_front #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  ftpg_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd),
    .empty  (q_empty)
  );

  ftpg_back #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .ink       (ink_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .stat      (back_stat)
  );

  `FTPG_ASSERT_IMPL(a_no_push_full, q_push, !q_full)
  `FTPG_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_empty)
  `FTPG_ASSERT_IMPL(a_newline_no_cmd,
    in_tvalid && in_tready && in_tdata[7:0] == ftpg_pkg::CODE_NEWLINE, !q_push)
  `FTPG_ASSERT_NEXT(a_pop_busy, q_pop, back_stat.busy)

endmodule
`default_nettype wire

### tb/font_text_pixel_generator_unit_checker.sv
`timescale 1ns / 1ps
// Pixel scoreboard for font_text_pixel_generator_unit: watches the character,
// pixel and colour channels, predicts each pixel and compares them in order.
// Depends on ftpg_pkg for the display size, newline code and cursor steps.
module font_text_pixel_generator_unit_checker
  import ftpg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_data,
  output int               pending,
  output int               errors,
  output int               pixels
);

  typedef struct packed {
    logic [6:0] x;
    logic [5:0] y;
    logic       color;
    logic       last;
  } pixel_t;

  pixel_t      pixel_q[$];
  logic [15:0] cur_col;
  logic [15:0] cur_row;
  logic [7:0]  line_col;
  logic        color;

  function automatic logic [15:0] advance_sat(input logic [15:0] v, input int d);
    int s;
    s = int'(v) + d;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  // row 0 in the top five bits, glyph column 0 is the high bit of each row
  function automatic logic [34:0] glyph_map(input logic [7:0] ch);
    logic [7:0] k;
    k = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (k)
      "!": return {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
      "B": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "E": return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "H": return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "L": return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "N": return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      "O": return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "P": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "R": return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      "S": return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "T": return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      "U": return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "0": return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      "1": return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "2": return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      "3": return {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
      "4": return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": return {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      "6": return {5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      "7": return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      "9": return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
      default: return '0;
    endcase
  endfunction

  task automatic draw_char(input logic [7:0] code, input logic ns,
                           input logic [7:0] ox, input logic [7:0] oy);
    logic [34:0] map;
    pixel_t      held;
    logic        have;
    int          px;
    int          py;
    if (ns) begin
      cur_col = {8'd0, ox};
      line_col = ox;
      cur_row = {8'd0, oy};
    end
    if (code == CODE_NEWLINE) begin
      cur_row = advance_sat(cur_row, ADVANCE_Y);
      cur_col = {8'd0, line_col};
    end else begin
      map = glyph_map(code);
      have = 1'b0;
      held = '0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
          px = int'(cur_col) + c;
          py = int'(cur_row) + r;
          if (map[34 - 5*r - c] && px < DISPLAY_WIDTH_DEF && py < DISPLAY_HEIGHT_DEF) begin
            if (have) pixel_q.push_back(held);
            held.x = 7'(DISPLAY_WIDTH_DEF - 1 - px);
            held.y = 6'(py);
            held.color = color;
            held.last = 1'b0;
            have = 1'b1;
          end
        end
      end
      if (have) begin
        held.last = 1'b1;
        pixel_q.push_back(held);
      end
      cur_col = advance_sat(cur_col, ADVANCE_X);
    end
  endtask

  function automatic int field_bad(input string name, input int want_v, input int got_v);
    if (want_v == got_v) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    int     bad;
    bad = 0;
    if (!rst_n) begin
      pixel_q.delete();
      cur_col = '0;
      cur_row = '0;
      line_col = '0;
      color = 1'b1;
      pending <= 0;
      errors <= 0;
      pixels <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[6:0];
        got.y = out_tdata[12:7];
        got.color = out_tdata[13];
        got.last = out_tlast;
        pixels <= pixels + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t: pixel expected none got x=%0d y=%0d color=%0d last=%0d",
                   $time, got.x, got.y, got.color, got.last);
          bad = 1;
        end else begin
          want = pixel_q.pop_front();
          bad += field_bad("pixel_x", want.x, got.x);
          bad += field_bad("pixel_y", want.y, got.y);
          bad += field_bad("pixel_color", want.color, got.color);
          bad += field_bad("last_pixel", want.last, got.last);
        end
      end
      if (cfg_valid && cfg_ready) color = cfg_data;
      if (in_tvalid && in_tready) begin
        draw_char(in_tdata[7:0], in_tuser, in_tdata[15:8], in_tdata[23:16]);
      end
      pending <= pixel_q.size();
      errors <= errors + bad;
    end
  end

endmodule

### tb/tb_font_text_pixel_generator_unit.sv
`timescale 1ns / 1ps
// Top of the font_text_pixel_generator_unit bench: drives characters, colour
// writes and random backpressure; the checker module scores every pixel.
// Depends on ftpg_pkg, the block and font_text_pixel_generator_unit_checker.
module tb_font_text_pixel_generator_unit;
  import ftpg_pkg::*;

  localparam logic [7:0]        CODE_SPACE   = 8'd32;
  localparam logic [8*22-1:0]   FONT_CHARS   = "!BEHLNOPRSTU0123456789";
  localparam longint            RUN_LIMIT_NS = 64'd60_000_000;
  localparam int                SETTLE_CYC   = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_ready;

  int pending;
  int errors;
  int pixels;
  int chars_sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  font_text_pixel_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  font_text_pixel_generator_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pending(pending), .errors(errors), .pixels(pixels)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 30) stall_left <= idle_len();
    end
  end

  task automatic send_char(input logic [7:0] code, input logic ns,
                           input logic [7:0] ox, input logic [7:0] oy);
    int gap;
    bit ok;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {oy, ox, code};
    in_tuser <= ns;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    chars_sent++;
  endtask

  task automatic write_color(input logic v);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every predicted pixel has been transferred
  task automatic wait_empty();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic settle();
    wait_empty();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int         r;
    int         idx;
    logic [7:0] ch;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      idx = $urandom_range(0, 21);
      ch = FONT_CHARS[8*idx +: 8];
      if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) ch = ch + 8'd32;
      return ch;
    end
    if (r < 70) return CODE_SPACE;
    if (r < 78) return CODE_NEWLINE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_text(input int count);
    int         sent;
    int         len;
    logic [7:0] ox;
    logic [7:0] oy;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      if ($urandom_range(0, 59) == 0) wait_empty();
      if ($urandom_range(0, 4) != 0) begin
        ox = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 122));
        oy = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 56));
        len = $urandom_range(2, 9);
        send_char(pick_char(), 1'b1, ox, oy);
        sent++;
        repeat (len - 1) begin
          send_char(pick_char(), 1'b0, 8'($urandom), 8'($urandom));
          sent++;
        end
      end else begin
        send_char(8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char("H", 1'b1, 8'd0, 8'd0);
    send_char("e", 1'b0, 8'd0, 8'd0);
    send_char("!", 1'b0, 8'd0, 8'd0);
    send_char("8", 1'b0, 8'd0, 8'd0);
    send_char(CODE_SPACE, 1'b0, 8'd0, 8'd0);
    send_char(8'h00, 1'b0, 8'd0, 8'd0);
    send_char(8'hFF, 1'b0, 8'hFF, 8'hFF);
    send_char(8'h80, 1'b0, 8'd0, 8'd0);
    send_char("A", 1'b0, 8'd0, 8'd0);
    send_char("z", 1'b0, 8'd0, 8'd0);
    send_char(CODE_NEWLINE, 1'b0, 8'd0, 8'd0);
    send_char("T", 1'b0, 8'd0, 8'd0);
    send_char("B", 1'b1, 8'd124, 8'd60);
    send_char("E", 1'b1, 8'd127, 8'd63);
    send_char("E", 1'b1, 8'd255, 8'd255);
    send_char("H", 1'b1, 8'd128, 8'd0);
    send_char("H", 1'b1, 8'd0, 8'd64);
    send_char("L", 1'b1, 8'd10, 8'd20);
    send_char("o", 1'b0, 8'd0, 8'd0);
    send_char(CODE_NEWLINE, 1'b0, 8'd0, 8'd0);
    send_char("P", 1'b0, 8'd0, 8'd0);
    send_char("S", 1'b0, 8'hFF, 8'hFF);
    send_char(CODE_NEWLINE, 1'b1, 8'd200, 8'd5);
    send_char("U", 1'b0, 8'd0, 8'd0);

    settle();
    write_color(1'b1);
    run_text(100);
    settle();
    write_color(1'b0);
    run_text(100);
    settle();
    write_color(1'($urandom));
    run_text(100);
    settle();
    write_color(1'b1);
    run_text(86);
    settle();

    $display("Sent %0d characters and checked %0d pixels under both draw colours,",
             chars_sent, pixels);
    $display("with clipping, mirroring, newlines, lowercase folding and unknown codes.");
    if (errors == 0) begin
      $display("[font_text_pixel_generator_unit] OK");
    end else begin
      $display("[font_text_pixel_generator_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[font_text_pixel_generator_unit] ERROR");
    $finish;
  end

endmodule
